// ===== rtl/ccbd_pkg.sv =====
// Shared types and constants for the character canvas box drawing block.
package ccbd_pkg;

   // command codes carried in the func field
   localparam logic [2:0] FUNC_CLEAR  = 3'd0;
   localparam logic [2:0] FUNC_HLINE  = 3'd1;
   localparam logic [2:0] FUNC_VLINE  = 3'd2;
   localparam logic [2:0] FUNC_BOX    = 3'd3;
   localparam logic [2:0] FUNC_STYLED = 3'd4;
   localparam logic [2:0] FUNC_PUT    = 3'd5;
   localparam logic [2:0] FUNC_READ   = 3'd6;

   // register indexes on the csr port
   localparam logic [2:0] CSR_COLS     = 3'd0;
   localparam logic [2:0] CSR_ROWS     = 3'd1;
   localparam logic [2:0] CSR_GLYPHS_A = 3'd2;
   localparam logic [2:0] CSR_GLYPHS_B = 3'd3;
   localparam logic [2:0] CSR_GLYPHS_C = 3'd4;
   localparam logic [2:0] CSR_GLYPHS_D = 3'd5;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_LOAD,
      ST_DRAW,
      ST_RESP
   } state_type;

   // MAIN is the whole run for lines, put and clear, the top row for boxes
   typedef enum logic [1:0] {
      SEG_MAIN,
      SEG_BOTTOM,
      SEG_LEFT,
      SEG_RIGHT
   } seg_type;

   typedef struct packed {
      logic    accept;
      logic    init_step;
      logic    load;
      logic    step;
      seg_type seg;
      logic    rsp_load;
   } ccbd_cmd_type;

   typedef struct packed {
      logic init_last;
      logic fault;
      logic is_read;
      logic is_box;
      logic seg_empty;
      logic last_cell;
   } ccbd_stat_type;

endpackage

// ===== rtl/ccbd_ctrl.sv =====
// Controller: sequences memory clearing, bounds check, segments and the response.
module ccbd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ccbd_pkg::ccbd_stat_type stat,
   output ccbd_pkg::ccbd_cmd_type  cmd
);

   ccbd_pkg::state_type state_ff, state_in;
   ccbd_pkg::seg_type   seg_ff, seg_in, seg_next;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                more_segs;
   logic                rsp_free;

   assign more_segs = stat.is_box && (seg_ff != ccbd_pkg::SEG_RIGHT);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (seg_ff)
         ccbd_pkg::SEG_MAIN:   seg_next = ccbd_pkg::SEG_BOTTOM;
         ccbd_pkg::SEG_BOTTOM: seg_next = ccbd_pkg::SEG_LEFT;
         ccbd_pkg::SEG_LEFT:   seg_next = ccbd_pkg::SEG_RIGHT;
         default:              seg_next = ccbd_pkg::SEG_RIGHT;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      case (state_ff)
         ccbd_pkg::ST_INIT: begin
            if (stat.init_last) state_in = ccbd_pkg::ST_IDLE;
         end
         ccbd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ccbd_pkg::ST_CHECK;
               seg_in   = ccbd_pkg::SEG_MAIN;
            end
         end
         ccbd_pkg::ST_CHECK: begin
            if (stat.fault)        state_in = ccbd_pkg::ST_RESP;
            else if (stat.is_read) state_in = ccbd_pkg::ST_READ;
            else                   state_in = ccbd_pkg::ST_LOAD;
         end
         ccbd_pkg::ST_READ: begin
            state_in = ccbd_pkg::ST_RESP;
         end
         ccbd_pkg::ST_LOAD: begin
            if (!stat.seg_empty) begin
               state_in = ccbd_pkg::ST_DRAW;
            end else if (more_segs) begin
               seg_in = seg_next;
            end else begin
               state_in = ccbd_pkg::ST_RESP;
            end
         end
         ccbd_pkg::ST_DRAW: begin
            if (stat.last_cell) begin
               if (more_segs) begin
                  state_in = ccbd_pkg::ST_LOAD;
                  seg_in   = seg_next;
               end else begin
                  state_in = ccbd_pkg::ST_RESP;
               end
            end
         end
         ccbd_pkg::ST_RESP: begin
            if (rsp_free) state_in = ccbd_pkg::ST_IDLE;
         end
         default: state_in = ccbd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = (state_ff == ccbd_pkg::ST_IDLE);
      cmd.accept    = (state_ff == ccbd_pkg::ST_IDLE) && req_tvalid;
      cmd.init_step = (state_ff == ccbd_pkg::ST_INIT);
      cmd.load      = (state_ff == ccbd_pkg::ST_LOAD);
      cmd.step      = (state_ff == ccbd_pkg::ST_DRAW);
      cmd.seg       = seg_ff;
      cmd.rsp_load  = (state_ff == ccbd_pkg::ST_RESP) && rsp_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccbd_pkg::ST_INIT;
         seg_ff       <= ccbd_pkg::SEG_MAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ccbd_dp.sv =====
// Datapath: registers, bounds check, segment scanner and the cell memory.
module ccbd_dp #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_addr,
   input  logic [31:0]            csr_wdata,
   input  logic [2:0]             req_func,
   input  logic [7:0]             req_x_pos,
   input  logic [6:0]             req_y_pos,
   input  logic [7:0]             req_span_w,
   input  logic [6:0]             req_span_h,
   input  logic [7:0]             req_glyph,
   input  ccbd_pkg::ccbd_cmd_type  cmd,
   output ccbd_pkg::ccbd_stat_type stat,
   output logic [7:0]             rsp_cell_char,
   output logic                   rsp_fault
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] COLS_K    = AW'(MAX_COLS);
   localparam logic [10:0]   COLS_CAP  = 11'(MAX_COLS);
   localparam logic [10:0]   ROWS_CAP  = 11'(MAX_ROWS);

   // styled glyph slots, register byte order
   localparam int G_SINGLE = 0;
   localparam int G_LLEFT  = 1;
   localparam int G_LMID   = 2;
   localparam int G_LRIGHT = 3;
   localparam int G_CTOP   = 4;
   localparam int G_CMID   = 5;
   localparam int G_CBOT   = 6;
   localparam int G_TL     = 7;
   localparam int G_TOP    = 8;
   localparam int G_TR     = 9;
   localparam int G_LEFT   = 10;
   localparam int G_RIGHT  = 11;
   localparam int G_BL     = 12;
   localparam int G_BOT    = 13;
   localparam int G_BR     = 14;

   // configuration
   logic [7:0]  cols_ff;
   logic [6:0]  rows_ff;
   logic [31:0] glyphs_a_ff, glyphs_b_ff, glyphs_c_ff;
   logic [23:0] glyphs_d_ff;

   // latched command
   logic [2:0] func_ff;
   logic [7:0] x_ff, w_ff, c_ff;
   logic [6:0] y_ff, h_ff;

   // scanner
   logic [7:0] cx_ff, cx_in, x0_ff, x1_ff;
   logic [6:0] cy_ff, cy_in, y1_ff;
   logic [7:0] gf_ff, gm_ff, gl_ff;

   // memory pipeline
   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] init_cnt_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic          we_ff, we_in;
   logic [7:0]    wdata_ff, wdata_in;
   logic [7:0]    rd_data_ff;

   logic [7:0] rsp_char_ff;
   logic       rsp_fault_ff;

   logic [7:0] cols_eff;
   logic [6:0] rows_eff;
   logic [8:0] xw;
   logic [7:0] yh;
   logic [7:0] xr;
   logic [6:0] yb;
   logic       fault;
   logic [7:0] g [15];
   logic [7:0] sx0, sx1, sf, sm, sl;
   logic [6:0] sy0, sy1;
   logic       sempty;
   logic [7:0] cur_glyph;
   logic       is_box;

   assign cols_eff = ({3'b000, cols_ff} < COLS_CAP) ? cols_ff : COLS_CAP[7:0];
   assign rows_eff = ({4'b0000, rows_ff} < ROWS_CAP) ? rows_ff : ROWS_CAP[6:0];

   assign xw = {1'b0, x_ff} + {1'b0, w_ff};
   assign yh = {1'b0, y_ff} + {1'b0, h_ff};
   assign xr = x_ff + w_ff - 8'd1;
   assign yb = y_ff + h_ff - 7'd1;

   assign is_box = (func_ff == ccbd_pkg::FUNC_BOX) || (func_ff == ccbd_pkg::FUNC_STYLED);

   always_comb begin
      case (func_ff)
         ccbd_pkg::FUNC_CLEAR:  fault = 1'b0;
         ccbd_pkg::FUNC_HLINE:  fault = !((xw <= {1'b0, cols_eff}) && (y_ff < rows_eff));
         ccbd_pkg::FUNC_VLINE:  fault = !((x_ff < cols_eff) && (yh <= {1'b0, rows_eff}));
         ccbd_pkg::FUNC_BOX,
         ccbd_pkg::FUNC_STYLED: fault = !((xw <= {1'b0, cols_eff}) &&
                                          (yh <= {1'b0, rows_eff}));
         ccbd_pkg::FUNC_PUT:    fault = !((x_ff < cols_eff) && (y_ff < rows_eff));
         ccbd_pkg::FUNC_READ:   fault = !((x_ff <= cols_eff) && (y_ff < rows_eff));
         default:               fault = 1'b1;
      endcase
   end

   // glyph set for boxes: the uniform box uses its one glyph everywhere
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         g[i]     = glyphs_a_ff[8*i +: 8];
         g[4 + i] = glyphs_b_ff[8*i +: 8];
         g[8 + i] = glyphs_c_ff[8*i +: 8];
      end
      for (int i = 0; i < 3; i++) begin
         g[12 + i] = glyphs_d_ff[8*i +: 8];
      end
      if (func_ff != ccbd_pkg::FUNC_STYLED) begin
         for (int i = 0; i < 15; i++) begin
            g[i] = c_ff;
         end
      end
   end

   // segment geometry; a one-wide row run only ever shows its first glyph
   always_comb begin
      sx0    = x_ff;
      sx1    = x_ff;
      sy0    = y_ff;
      sy1    = y_ff;
      sf     = c_ff;
      sm     = c_ff;
      sl     = c_ff;
      sempty = 1'b1;
      case (cmd.seg)
         ccbd_pkg::SEG_MAIN: begin
            case (func_ff)
               ccbd_pkg::FUNC_CLEAR: begin
                  sx0    = 8'd0;
                  sx1    = cols_eff - 8'd1;
                  sy0    = 7'd0;
                  sy1    = rows_eff - 7'd1;
                  sf     = ccbd_pkg::CHAR_SPACE;
                  sm     = ccbd_pkg::CHAR_SPACE;
                  sl     = ccbd_pkg::CHAR_SPACE;
                  sempty = (cols_eff == 8'd0) || (rows_eff == 7'd0);
               end
               ccbd_pkg::FUNC_HLINE: begin
                  sx1    = xr;
                  sempty = (w_ff == 8'd0);
               end
               ccbd_pkg::FUNC_VLINE: begin
                  sy1    = yb;
                  sempty = (h_ff == 7'd0);
               end
               ccbd_pkg::FUNC_PUT: begin
                  sempty = 1'b0;
               end
               ccbd_pkg::FUNC_BOX,
               ccbd_pkg::FUNC_STYLED: begin
                  sx1    = xr;
                  sempty = (w_ff == 8'd0) || (h_ff == 7'd0);
                  if (h_ff == 7'd1) begin
                     sf = (w_ff == 8'd1) ? g[G_SINGLE] : g[G_LLEFT];
                     sm = g[G_LMID];
                     sl = g[G_LRIGHT];
                  end else begin
                     sf = (w_ff == 8'd1) ? g[G_CTOP] : g[G_TL];
                     sm = g[G_TOP];
                     sl = g[G_TR];
                  end
               end
               default: sempty = 1'b1;
            endcase
         end
         ccbd_pkg::SEG_BOTTOM: begin
            sx1    = xr;
            sy0    = yb;
            sy1    = yb;
            sf     = (w_ff == 8'd1) ? g[G_CBOT] : g[G_BL];
            sm     = g[G_BOT];
            sl     = g[G_BR];
            sempty = (w_ff == 8'd0) || (h_ff < 7'd2);
         end
         ccbd_pkg::SEG_LEFT: begin
            sy0    = y_ff + 7'd1;
            sy1    = yb - 7'd1;
            sf     = (w_ff == 8'd1) ? g[G_CMID] : g[G_LEFT];
            sm     = sf;
            sl     = sf;
            sempty = (w_ff == 8'd0) || (h_ff < 7'd3);
         end
         default: begin
            sx0    = xr;
            sx1    = xr;
            sy0    = y_ff + 7'd1;
            sy1    = yb - 7'd1;
            sf     = g[G_RIGHT];
            sm     = g[G_RIGHT];
            sl     = g[G_RIGHT];
            sempty = (w_ff < 8'd2) || (h_ff < 7'd3);
         end
      endcase
   end

   assign cur_glyph = (cx_ff == x0_ff) ? gf_ff : ((cx_ff == x1_ff) ? gl_ff : gm_ff);

   // cursor walks row-major through the segment rectangle
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cmd.accept) begin
         cx_in = req_x_pos;
         cy_in = req_y_pos;
      end else if (cmd.load) begin
         cx_in = sx0;
         cy_in = sy0;
      end else if (cmd.step) begin
         if (cx_ff == x1_ff) begin
            cx_in = x0_ff;
            cy_in = cy_ff + 7'd1;
         end else begin
            cx_in = cx_ff + 8'd1;
         end
      end
   end

   always_comb begin
      if (cmd.init_step) begin
         addr_in  = init_cnt_ff;
         wdata_in = ccbd_pkg::CHAR_SPACE;
      end else begin
         addr_in  = AW'(cy_ff) * COLS_K + AW'(cx_ff);
         wdata_in = cur_glyph;
      end
      we_in = cmd.init_step || cmd.step;
   end

   always_comb begin
      stat.init_last = (init_cnt_ff == LAST_ADDR);
      stat.fault     = fault;
      stat.is_read   = (func_ff == ccbd_pkg::FUNC_READ);
      stat.is_box    = is_box;
      stat.seg_empty = sempty;
      stat.last_cell = (cx_ff == x1_ff) && (cy_ff == y1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= 8'd80;
         rows_ff     <= 7'd25;
         glyphs_a_ff <= 32'h2020_2020;
         glyphs_b_ff <= 32'h2020_2020;
         glyphs_c_ff <= 32'h2020_2020;
         glyphs_d_ff <= 24'h20_2020;
         init_cnt_ff <= '0;
         we_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               ccbd_pkg::CSR_COLS:     cols_ff     <= csr_wdata[7:0];
               ccbd_pkg::CSR_ROWS:     rows_ff     <= csr_wdata[6:0];
               ccbd_pkg::CSR_GLYPHS_A: glyphs_a_ff <= csr_wdata;
               ccbd_pkg::CSR_GLYPHS_B: glyphs_b_ff <= csr_wdata;
               ccbd_pkg::CSR_GLYPHS_C: glyphs_c_ff <= csr_wdata;
               ccbd_pkg::CSR_GLYPHS_D: glyphs_d_ff <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (cmd.init_step) init_cnt_ff <= init_cnt_ff + AW'(1);
         we_ff <= we_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         x_ff    <= req_x_pos;
         y_ff    <= req_y_pos;
         w_ff    <= req_span_w;
         h_ff    <= req_span_h;
         c_ff    <= req_glyph;
      end
      if (cmd.load) begin
         x0_ff <= sx0;
         x1_ff <= sx1;
         y1_ff <= sy1;
         gf_ff <= sf;
         gm_ff <= sm;
         gl_ff <= sl;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      if (cmd.rsp_load) begin
         rsp_fault_ff <= fault;
         if (fault || (func_ff != ccbd_pkg::FUNC_READ)) rsp_char_ff <= 8'd0;
         else if (x_ff == cols_eff)                     rsp_char_ff <= ccbd_pkg::CHAR_NEWLINE;
         else                                           rsp_char_ff <= rd_data_ff;
      end
   end

   // cell store: one write port, registered read
   always_ff @(posedge clock) begin
      if (we_ff) mem[addr_ff] <= wdata_ff;
      rd_data_ff <= mem[addr_ff];
   end

   assign rsp_cell_char = rsp_char_ff;
   assign rsp_fault     = rsp_fault_ff;

endmodule

// ===== rtl/char_canvas_box_draw.sv =====
// Top level of the character canvas with line and box drawing.
//
//  port group  dir  beat contents
//  req_*       in   tdata: func, x_pos, y_pos, span_w, span_h, glyph
//  rsp_*       out  tdata: cell_char; tuser: fault
//  csr_*       in   write enable, register index, write data
//
// One command at a time: a bounds check, one segment load per segment (1 for a line,
// put or clear, 4 for a box) and one write per cell, then the response; a read makes
// a memory read instead of segments, a rejected command goes straight to the response.
// After reset the memory is swept to spaces, all MAX_COLS*MAX_ROWS cells
// (8192 by default), with req_tready low; csr writes are taken meanwhile.
// A stalled response holds; the next command may be taken meanwhile.
module char_canvas_box_draw #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // func, x_pos, y_pos, span_w, span_h, glyph, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // cell_char
   output logic        rsp_tuser,  // fault
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   ccbd_pkg::ccbd_cmd_type  cmd;
   ccbd_pkg::ccbd_stat_type stat;

   ccbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccbd_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_func      (req_tdata[2:0]),
      .req_x_pos     (req_tdata[10:3]),
      .req_y_pos     (req_tdata[17:11]),
      .req_span_w    (req_tdata[25:18]),
      .req_span_h    (req_tdata[32:26]),
      .req_glyph     (req_tdata[40:33]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_cell_char (rsp_tdata),
      .rsp_fault     (rsp_tuser)
   );

endmodule

// ===== rtl/ccbd_checker.sv =====
// Port-level checks for the canvas block, bound to the top level.
module ccbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // memory sweep keeps the input closed right after reset
   a_init_closed: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high during memory sweep");

   // one command in flight: no back-to-back accepts
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat accepted while a command is in flight");

   // a rejected command carries no character
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 8'd0))
      else $error("faulted response with nonzero cell_char");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

endmodule

bind char_canvas_box_draw ccbd_checker u_ccbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/char_canvas_box_draw_tb.sv =====
// Self-checking testbench for the character canvas line and box drawing block.
`timescale 1ns / 1ps

module char_canvas_box_draw_tb;

   localparam int CANVAS_MAX_COLS = 128;
   localparam int CANVAS_MAX_ROWS = 64;
   localparam logic [2:0] FUNC_UNDEFINED = 3'd7;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int NUM_PHASES = 10;

   // first field in the low bits
   typedef struct packed {
      logic [7:0] glyph;
      logic [6:0] span_h;
      logic [7:0] span_w;
      logic [6:0] y_pos;
      logic [7:0] x_pos;
      logic [2:0] func;
   } draw_cmd_type;

   typedef struct packed {
      logic       fault;
      logic [7:0] cell_char;
   } draw_rsp_type;

   localparam int CMD_BITS = $bits(draw_cmd_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = ccbd_pkg::CSR_COLS;
   logic [31:0] csr_wdata = '0;

   // shadow of the canvas and its registers
   logic [7:0]  canvas_mem [0:CANVAS_MAX_COLS*CANVAS_MAX_ROWS-1];
   int          cols_setting = 80;
   int          rows_setting = 25;
   logic [31:0] glyphs_a_reg = 32'h20202020;
   logic [31:0] glyphs_b_reg = 32'h20202020;
   logic [31:0] glyphs_c_reg = 32'h20202020;
   logic [23:0] glyphs_d_reg = 24'h202020;

   draw_cmd_type cmd_queue [$];
   draw_rsp_type expected_rsp [$];
   draw_cmd_type pending_cmd;
   int           gap_left = 0;
   int           stall_left = 0;
   int           error_count = 0;
   bit           throttle_on = 1'b1;

   char_canvas_box_draw #(
      .MAX_COLS(CANVAS_MAX_COLS),
      .MAX_ROWS(CANVAS_MAX_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int eff_cols();
      return (cols_setting < CANVAS_MAX_COLS) ? cols_setting : CANVAS_MAX_COLS;
   endfunction

   function automatic int eff_rows();
      return (rows_setting < CANVAS_MAX_ROWS) ? rows_setting : CANVAS_MAX_ROWS;
   endfunction

   function automatic void put_cell(int x, int y, logic [7:0] ch);
      if (x < CANVAS_MAX_COLS && y < CANVAS_MAX_ROWS)
         canvas_mem[y*CANVAS_MAX_COLS + x] = ch;
   endfunction

   function automatic void run_row(int x, int y, int len, logic [7:0] ch);
      for (int i = 0; i < len; i++) put_cell(x + i, y, ch);
   endfunction

   function automatic void run_col(int x, int y, int len, logic [7:0] ch);
      for (int i = 0; i < len; i++) put_cell(x, y + i, ch);
   endfunction

   // gset byte order: single, line l/m/r, column t/m/b, corners and edges
   function automatic void draw_outline(int x, int y, int w, int h,
                                        logic [14:0][7:0] gset);
      int xr;
      int yb;
      if (w == 0 || h == 0) return;
      xr = x + w - 1;
      yb = y + h - 1;
      if (h == 1) begin
         if (w == 1) begin
            put_cell(x, y, gset[0]);
         end else begin
            put_cell(x, y, gset[1]);
            put_cell(xr, y, gset[3]);
            run_row(x + 1, y, w - 2, gset[2]);
         end
      end else if (w == 1) begin
         put_cell(x, y, gset[4]);
         put_cell(x, yb, gset[6]);
         run_col(x, y + 1, h - 2, gset[5]);
      end else begin
         put_cell(x, y, gset[7]);
         put_cell(xr, y, gset[9]);
         put_cell(x, yb, gset[12]);
         put_cell(xr, yb, gset[14]);
         run_row(x + 1, y, w - 2, gset[8]);
         run_row(x + 1, yb, w - 2, gset[13]);
         run_col(x, y + 1, h - 2, gset[10]);
         run_col(xr, y + 1, h - 2, gset[11]);
      end
   endfunction

   // updates the shadow canvas and returns the beat the block must answer with
   function automatic draw_rsp_type apply_command(draw_cmd_type cmd);
      int x;
      int y;
      int w;
      int h;
      int c;
      int r;
      draw_rsp_type rsp;
      x = cmd.x_pos;
      y = cmd.y_pos;
      w = cmd.span_w;
      h = cmd.span_h;
      c = eff_cols();
      r = eff_rows();
      rsp = '0;
      case (cmd.func)
         ccbd_pkg::FUNC_CLEAR: begin
            for (int row = 0; row < r; row++) run_row(0, row, c, ccbd_pkg::CHAR_SPACE);
         end
         ccbd_pkg::FUNC_HLINE: begin
            if (x + w <= c && y < r) run_row(x, y, w, cmd.glyph);
            else rsp.fault = 1'b1;
         end
         ccbd_pkg::FUNC_VLINE: begin
            if (x < c && y + h <= r) run_col(x, y, h, cmd.glyph);
            else rsp.fault = 1'b1;
         end
         ccbd_pkg::FUNC_BOX, ccbd_pkg::FUNC_STYLED: begin
            if (x + w <= c && y + h <= r) begin
               if (cmd.func == ccbd_pkg::FUNC_BOX)
                  draw_outline(x, y, w, h, {15{cmd.glyph}});
               else
                  draw_outline(x, y, w, h,
                               {glyphs_d_reg, glyphs_c_reg, glyphs_b_reg, glyphs_a_reg});
            end else begin
               rsp.fault = 1'b1;
            end
         end
         ccbd_pkg::FUNC_PUT: begin
            if (x < c && y < r) put_cell(x, y, cmd.glyph);
            else rsp.fault = 1'b1;
         end
         ccbd_pkg::FUNC_READ: begin
            if (x < c && y < r) rsp.cell_char = canvas_mem[y*CANVAS_MAX_COLS + x];
            else if (x == c && y < r) rsp.cell_char = ccbd_pkg::CHAR_NEWLINE;
            else rsp.fault = 1'b1;
         end
         default: rsp.fault = 1'b1;
      endcase
      return rsp;
   endfunction

   function automatic int random_gap();
      int p;
      if (!throttle_on) return 0;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 85) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(15, 4);
      return $urandom_range(120, 20);
   endfunction

   function automatic void queue_cmd(logic [2:0] func, int x, int y, int w, int h,
                                     logic [7:0] glyph);
      draw_cmd_type cmd;
      cmd.func = func;
      cmd.x_pos = 8'(x);
      cmd.y_pos = 7'(y);
      cmd.span_w = 8'(w);
      cmd.span_h = 7'(h);
      cmd.glyph = glyph;
      cmd_queue.push_back(cmd);
   endfunction

   function automatic int short_span(int limit);
      if ($urandom_range(9) == 0) return $urandom_range(limit);
      return $urandom_range(limit < 6 ? limit : 6);
   endfunction

   // mostly in-bounds commands sized to the current canvas, some raw noise
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type cmd;
      int c;
      int r;
      int p;
      int wmax;
      int hmax;
      c = eff_cols();
      r = eff_rows();
      cmd = draw_cmd_type'(CMD_BITS'({$urandom, $urandom}));
      if ($urandom_range(99) < 12 || c == 0 || r == 0) begin
         if ($urandom_range(1)) begin
            // near the origin so that empty draws can pass on a zero canvas
            cmd.x_pos = 8'($urandom_range(2));
            cmd.y_pos = 7'($urandom_range(2));
            cmd.span_w = 8'($urandom_range(2));
            cmd.span_h = 7'($urandom_range(2));
         end
         return cmd;
      end
      p = $urandom_range(99);
      if (p < 2) cmd.func = ccbd_pkg::FUNC_CLEAR;
      else if (p < 14) cmd.func = ccbd_pkg::FUNC_HLINE;
      else if (p < 26) cmd.func = ccbd_pkg::FUNC_VLINE;
      else if (p < 40) cmd.func = ccbd_pkg::FUNC_BOX;
      else if (p < 58) cmd.func = ccbd_pkg::FUNC_STYLED;
      else if (p < 72) cmd.func = ccbd_pkg::FUNC_PUT;
      else cmd.func = ccbd_pkg::FUNC_READ;
      cmd.x_pos = 8'($urandom_range(c - 1));
      cmd.y_pos = 7'($urandom_range(r - 1));
      wmax = c - cmd.x_pos;
      hmax = r - cmd.y_pos;
      cmd.span_w = 8'(short_span(wmax));
      cmd.span_h = 7'(short_span(hmax));
      if ($urandom_range(19) == 0) begin
         // just past the edge
         cmd.span_w = 8'(wmax + $urandom_range(1));
         cmd.span_h = 7'(hmax + $urandom_range(1));
         if (cmd.func == ccbd_pkg::FUNC_PUT || cmd.func == ccbd_pkg::FUNC_READ)
            cmd.x_pos = 8'(c + $urandom_range(1));
      end else if (cmd.func == ccbd_pkg::FUNC_READ && $urandom_range(9) == 0) begin
         cmd.x_pos = 8'(c);
      end
      return cmd;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         ccbd_pkg::CSR_COLS:     cols_setting = value[7:0];
         ccbd_pkg::CSR_ROWS:     rows_setting = value[6:0];
         ccbd_pkg::CSR_GLYPHS_A: glyphs_a_reg = value;
         ccbd_pkg::CSR_GLYPHS_B: glyphs_b_reg = value;
         ccbd_pkg::CSR_GLYPHS_C: glyphs_c_reg = value;
         ccbd_pkg::CSR_GLYPHS_D: glyphs_d_reg = value[23:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // checked on the falling edge, once the driver's updates have settled
   task automatic wait_drained();
      while (cmd_queue.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_rsp.push_back(apply_command(pending_cmd));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               pending_cmd = cmd_queue.pop_front();
               req_tdata <= {7'b0, pending_cmd};
               req_tvalid <= 1'b1;
               gap_left = random_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin : watch_rsp
      draw_rsp_type got;
      draw_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cell_char = rsp_tdata;
            got.fault = rsp_tuser;
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected beat char=%h fault=%b", $realtime,
                           got.cell_char, got.fault);
            end else begin
               want = expected_rsp.pop_front();
               if (got.cell_char !== want.cell_char || got.fault !== want.fault) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: mismatch char exp=%h got=%h fault exp=%b got=%b",
                              $realtime, want.cell_char, got.cell_char, want.fault,
                              got.fault);
               end
            end
         end
         if (stall_left > 0) stall_left--;
         else if ($urandom_range(3) == 0) stall_left = random_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   initial begin : run_test
      int phase_cols [NUM_PHASES];
      int phase_rows [NUM_PHASES];
      logic [31:0] gword;
      phase_cols = '{128, 1, 0, 255, 7, 128, 1, 0, 40, 200};
      phase_rows = '{64, 1, 0, 127, 5, 1, 64, 9, 30, 0};
      for (int i = 0; i < CANVAS_MAX_COLS*CANVAS_MAX_ROWS; i++)
         canvas_mem[i] = ccbd_pkg::CHAR_SPACE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // small canvas with a recognizable glyph set ('a' .. 'o')
      write_reg(ccbd_pkg::CSR_COLS, 32'd20);
      write_reg(ccbd_pkg::CSR_ROWS, 32'd10);
      write_reg(ccbd_pkg::CSR_GLYPHS_A, 32'h64636261);
      write_reg(ccbd_pkg::CSR_GLYPHS_B, 32'h68676665);
      write_reg(ccbd_pkg::CSR_GLYPHS_C, 32'h6C6B6A69);
      write_reg(ccbd_pkg::CSR_GLYPHS_D, 32'h006F6E6D);

      queue_cmd(ccbd_pkg::FUNC_PUT, 0, 0, 0, 0, "A");
      queue_cmd(ccbd_pkg::FUNC_READ, 0, 0, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_HLINE, 2, 1, 5, 0, "-");
      queue_cmd(ccbd_pkg::FUNC_VLINE, 19, 0, 0, 10, "|");
      queue_cmd(ccbd_pkg::FUNC_READ, 19, 9, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_BOX, 5, 3, 4, 4, "#");
      queue_cmd(ccbd_pkg::FUNC_READ, 6, 4, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_STYLED, 10, 2, 5, 3, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_READ, 14, 4, 0, 0, 8'h00);
      // thin boxes: single cell, one row, one column
      queue_cmd(ccbd_pkg::FUNC_STYLED, 0, 8, 1, 1, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_STYLED, 1, 9, 5, 1, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_STYLED, 0, 5, 1, 3, 8'h00);
      // empty boxes and zero-length lines at the far edges
      queue_cmd(ccbd_pkg::FUNC_BOX, 3, 3, 0, 4, "*");
      queue_cmd(ccbd_pkg::FUNC_STYLED, 3, 3, 4, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_HLINE, 20, 0, 0, 0, "=");
      queue_cmd(ccbd_pkg::FUNC_VLINE, 0, 10, 0, 0, "=");
      // newline past the last column, then faults
      queue_cmd(ccbd_pkg::FUNC_READ, 20, 0, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_READ, 21, 0, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_READ, 0, 10, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_HLINE, 15, 0, 6, 0, "x");
      queue_cmd(ccbd_pkg::FUNC_BOX, 18, 8, 3, 2, "x");
      queue_cmd(ccbd_pkg::FUNC_PUT, 20, 0, 0, 0, "x");
      queue_cmd(FUNC_UNDEFINED, 1, 1, 1, 1, "x");
      queue_cmd(ccbd_pkg::FUNC_HLINE, 255, 127, 255, 127, 8'hFF);
      queue_cmd(ccbd_pkg::FUNC_PUT, 19, 9, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_CLEAR, 0, 0, 0, 0, 8'h00);
      queue_cmd(ccbd_pkg::FUNC_READ, 2, 1, 0, 0, 8'h00);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         throttle_on = (ph % 3 != 1);
         write_reg(ccbd_pkg::CSR_COLS, phase_cols[ph]);
         write_reg(ccbd_pkg::CSR_ROWS, phase_rows[ph]);
         for (int k = 0; k < 4; k++) begin
            gword = (ph == 1) ? 32'hFFFFFFFF : (ph == 2) ? 32'h0 : $urandom;
            write_reg(3'(ccbd_pkg::CSR_GLYPHS_A + k), gword);
         end
         if (ph % 2 == 0) queue_cmd(ccbd_pkg::FUNC_CLEAR, 0, 0, 0, 0, 8'h00);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) cmd_queue.push_back(random_cmd());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ccbd_pkg.sv
rtl/ccbd_ctrl.sv
rtl/ccbd_dp.sv
rtl/char_canvas_box_draw.sv
rtl/ccbd_checker.sv
tb/char_canvas_box_draw_tb.sv
